FILE: sv/ultrasonic_ranging_change_detector_macros.svh
// Assertion macros shared by the ranging block modules
`ifndef ULTRASONIC_RANGING_CHANGE_DETECTOR_MACROS_SVH
`define ULTRASONIC_RANGING_CHANGE_DETECTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define URCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define URCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/urcd_pkg.sv
// Types and constants for the ultrasonic ranging change detector
`default_nettype none
package urcd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned DIST_W     = 15;
  localparam int unsigned TICK_W     = 22;
  localparam int unsigned WIDTH_W    = 20;
  localparam int unsigned PROD_W     = 29;

  // mm-free scale: one microsecond of echo width gives 281/1024 of 1/16 cm
  localparam logic [PROD_W-1:0] DIST_SCALE = 29'd281;
  localparam logic [DIST_W-1:0] DIST_MAX   = 15'd32767;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd5;

  localparam logic [1:0] ST_FIRST   = 2'd0;
  localparam logic [1:0] ST_NORMAL  = 2'd1;
  localparam logic [1:0] ST_ANOMALY = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_TRIG    = 3'd2,
    PH_WAIT    = 3'd3,
    PH_MEASURE = 3'd4,
    PH_GAP     = 3'd5
  } phase_t;

  typedef struct packed {
    logic              trigger_level;
    logic              done_res;
    logic [DIST_W-1:0] distance;
    logic [1:0]        status;
    logic              anomaly;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/ultrasonic_ranging_change_detector.sv
// The sequencer updates all state and the output buffer registers the result of
// each accepted tick item; one tick item per cycle is taken while in_stall is low.
// A two-entry output buffer keeps taking ticks under output stall until both fill.
// in_stall rises only while both buffer entries hold results.
// Synchronous active-low reset idles the sequencer, config registers at their defaults.
`default_nettype none
module ultrasonic_ranging_change_detector
  import urcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_echo_level,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_trigger_level,
  output logic                       out_done_res,
  output logic [DIST_W-1:0]          out_distance,
  output logic [1:0]                 out_status,
  output logic                       out_anomaly
);

  logic    accept;
  logic    buf_full;
  result_t step_res;
  result_t out_res;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  urcd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step       (accept),
    .echo_level (in_echo_level),
    .res        (step_res)
  );

  urcd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_trigger_level = out_res.trigger_level;
  assign out_done_res      = out_res.done_res;
  assign out_distance      = out_res.distance;
  assign out_status        = out_res.status;
  assign out_anomaly       = out_res.anomaly;

endmodule
`default_nettype wire

FILE: sv/urcd_core.sv
// Ranging sequencer: configuration, phase control, timing and change detection
`default_nettype none
`include "ultrasonic_ranging_change_detector_macros.svh"
module urcd_core
  import urcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  step,
  input  wire logic                  echo_level,
  output result_t                    res
);

  logic                  enable_r;
  logic [7:0]            settle_ticks_r;
  logic [7:0]            trigger_ticks_r;
  logic [WIDTH_W-1:0]    timeout_ticks_r;
  logic [TICK_W-1:0]     interval_ticks_r;
  logic [DIST_W-1:0]     threshold_r;

  phase_t                phase_r, phase_nxt;
  logic [TICK_W-1:0]     tick_count_r, tick_count_nxt;
  logic [WIDTH_W-1:0]    pulse_width_r, pulse_width_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [DIST_W-1:0]     ref_dist_r, ref_dist_nxt;
  logic                  ref_valid_r, ref_valid_nxt;
  logic                  anomaly_r, anomaly_nxt;

  logic [TICK_W-1:0]     tick_inc;
  logic [DIST_W-1:0]     dist_now;
  logic [DIST_W-1:0]     diff;
  logic                  over;
  phase_t                start_phase;
  phase_t                gap_phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r         <= 1'b0;
      settle_ticks_r   <= 8'd2;
      trigger_ticks_r  <= 8'd10;
      timeout_ticks_r  <= 20'd100000;
      interval_ticks_r <= 22'd2000000;
      threshold_r      <= 15'd160;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ENABLE:    enable_r         <= cfg_data[0];
        CFG_SETTLE:    settle_ticks_r   <= cfg_data[7:0];
        CFG_TRIGGER:   trigger_ticks_r  <= cfg_data[7:0];
        CFG_TIMEOUT:   timeout_ticks_r  <= cfg_data[WIDTH_W-1:0];
        CFG_INTERVAL:  interval_ticks_r <= cfg_data[TICK_W-1:0];
        CFG_THRESHOLD: threshold_r      <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick_inc = tick_count_r + 1'b1;

  // prod_r tracks pulse_width * 281, so the distance is a slice and clamp
  assign dist_now = (prod_r[PROD_W-1:DIST_W+10] != '0) ? DIST_MAX : prod_r[DIST_W+9:10];
  assign diff     = (dist_now > ref_dist_r) ? dist_now - ref_dist_r : ref_dist_r - dist_now;
  assign over     = diff > threshold_r;

  assign start_phase = !enable_r ? PH_IDLE : (settle_ticks_r == 8'd0) ? PH_TRIG : PH_SETTLE;
  assign gap_phase   = (interval_ticks_r == '0) ? start_phase : PH_GAP;

  // next state
  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    pulse_width_nxt = pulse_width_r;
    prod_nxt        = prod_r;
    ref_dist_nxt    = ref_dist_r;
    ref_valid_nxt   = ref_valid_r;
    anomaly_nxt     = anomaly_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (enable_r) begin
          phase_nxt      = start_phase;
          tick_count_nxt = '0;
        end
      end
      PH_SETTLE: begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= TICK_W'(settle_ticks_r)) begin
          phase_nxt      = PH_TRIG;
          tick_count_nxt = '0;
        end
      end
      PH_TRIG: begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= TICK_W'(trigger_ticks_r)) begin
          phase_nxt      = PH_WAIT;
          tick_count_nxt = '0;
        end
      end
      PH_WAIT: begin
        if (echo_level) begin
          phase_nxt       = PH_MEASURE;
          pulse_width_nxt = WIDTH_W'(1);
          prod_nxt        = DIST_SCALE;
          tick_count_nxt  = '0;
        end else begin
          tick_count_nxt = tick_inc;
          if (tick_inc > TICK_W'(timeout_ticks_r)) begin
            phase_nxt       = gap_phase;
            tick_count_nxt  = '0;
            pulse_width_nxt = '0;
            prod_nxt        = '0;
          end
        end
      end
      PH_MEASURE: begin
        if (echo_level) begin
          if (pulse_width_r >= timeout_ticks_r) begin
            phase_nxt       = gap_phase;
            tick_count_nxt  = '0;
            pulse_width_nxt = '0;
            prod_nxt        = '0;
          end else begin
            pulse_width_nxt = pulse_width_r + 1'b1;
            prod_nxt        = prod_r + DIST_SCALE;
          end
        end else begin
          if (ref_valid_r) begin
            anomaly_nxt = over;
          end
          ref_valid_nxt   = 1'b1;
          ref_dist_nxt    = dist_now;
          phase_nxt       = gap_phase;
          tick_count_nxt  = '0;
          pulse_width_nxt = '0;
          prod_nxt        = '0;
        end
      end
      PH_GAP: begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= interval_ticks_r) begin
          phase_nxt      = start_phase;
          tick_count_nxt = '0;
        end
      end
      default: begin
        phase_nxt      = PH_IDLE;
        tick_count_nxt = '0;
      end
    endcase
  end

  // result for this tick
  always_comb begin
    res               = '0;
    res.anomaly       = anomaly_nxt;
    unique case (phase_r)
      PH_TRIG: res.trigger_level = 1'b1;
      PH_WAIT: begin
        if (!echo_level && tick_inc > TICK_W'(timeout_ticks_r)) begin
          res.done_res = 1'b1;
          res.status   = ST_TIMEOUT;
        end
      end
      PH_MEASURE: begin
        if (echo_level) begin
          if (pulse_width_r >= timeout_ticks_r) begin
            res.done_res = 1'b1;
            res.status   = ST_TIMEOUT;
          end
        end else begin
          res.done_res = 1'b1;
          res.distance = dist_now;
          res.status   = !ref_valid_r ? ST_FIRST : (over ? ST_ANOMALY : ST_NORMAL);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= '0;
      pulse_width_r <= '0;
      prod_r        <= '0;
      ref_dist_r    <= '0;
      ref_valid_r   <= 1'b0;
      anomaly_r     <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      pulse_width_r <= pulse_width_nxt;
      prod_r        <= prod_nxt;
      ref_dist_r    <= ref_dist_nxt;
      ref_valid_r   <= ref_valid_nxt;
      anomaly_r     <= anomaly_nxt;
    end
  end

  `URCD_ASSERT_NEXT(a_ref_valid_sticks, ref_valid_r, ref_valid_r, "reference valid dropped")
  `URCD_ASSERT_NOW(a_prod_tracks_width, phase_r == PH_MEASURE, prod_r == PROD_W'(pulse_width_r) * DIST_SCALE, "product out of step with pulse width")
  `URCD_ASSERT_NOW(a_anomaly_needs_ref, anomaly_r, ref_valid_r, "anomaly flag without reference")

endmodule
`default_nettype wire

FILE: sv/urcd_skid.sv
// Two-entry result buffer: output register plus skid register
`default_nettype none
`include "ultrasonic_ranging_change_detector_macros.svh"
module urcd_skid
  import urcd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t main_r;
  result_t skid_r;
  logic    out_fire;

  assign out_fire = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = main_r;

  `URCD_ASSERT_NOW(a_skid_behind_main, skid_valid_r, out_valid_r, "skid entry with empty output")
  `URCD_ASSERT_NEXT(a_skid_holds, skid_valid_r && out_stall, skid_valid_r && $stable(skid_r), "skid entry lost while stalled")
  `URCD_ASSERT_NEXT(a_push_lands, push && !skid_valid_r, out_valid_r, "pushed item not held")

endmodule
`default_nettype wire
